@@ rtl/b2da_pkg.sv @@
// shared types and constants of the binary to decimal ascii converter
`default_nettype none
package b2da_pkg;

  localparam int IN_W        = 64;
  localparam int VALUE_WIDTH = 64;
  localparam int NUM_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_W       = 4 * NUM_DIGITS;
  localparam int BIT_CNT_W   = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam int DIG_W       = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int CHAR_W      = 6;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic shift_bit;
    logic shift_dig;
  } cmd_t;

  typedef struct packed {
    logic bit_done;
    logic top_zero;
    logic dig_last;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/b2da_if.sv @@
// valid/ready channel interfaces for input values and output digits
`default_nettype none
interface b2da_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] number_in;

  modport source (output valid, output number_in, input ready);
  modport sink   (input valid, input number_in, output ready);
endinterface

interface b2da_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] digit_char;
  logic       last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface
`default_nettype wire

@@ rtl/b2da_dp.sv @@
// datapath: shift-and-add-3 converter, digit shifter and counters
`default_nettype none
module b2da_dp (
  input  wire logic                        clk,
  input  wire logic [b2da_pkg::IN_W-1:0]   number_in,
  input  wire b2da_pkg::cmd_t              cmd,
  output b2da_pkg::sts_t                   sts,
  output logic [b2da_pkg::CHAR_W-1:0]      digit_char,
  output logic                             last_digit
);
  import b2da_pkg::*;

  logic [VALUE_WIDTH-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt;
  logic [BCD_W-1:0]       bcd_adj;
  logic [BIT_CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [DIG_W-1:0]       dig_cnt_r, dig_cnt_nxt;
  logic [3:0]             top_dig;

  // add 3 to every digit of 5 or more
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? (bcd_r[4*i +: 4] + 4'd3)
                                                     : bcd_r[4*i +: 4];
    end
  end

  always_comb begin
    bin_nxt     = bin_r;
    bcd_nxt     = bcd_r;
    bit_cnt_nxt = bit_cnt_r;
    dig_cnt_nxt = dig_cnt_r;
    if (cmd.load) begin
      bin_nxt     = number_in[VALUE_WIDTH-1:0];
      bcd_nxt     = '0;
      bit_cnt_nxt = '0;
      dig_cnt_nxt = '0;
    end else if (cmd.shift_bit) begin
      bin_nxt     = {bin_r[VALUE_WIDTH-2:0], 1'b0};
      bcd_nxt     = {bcd_adj[BCD_W-2:0], bin_r[VALUE_WIDTH-1]};
      bit_cnt_nxt = bit_cnt_r + 1'b1;
    end else if (cmd.shift_dig) begin
      bcd_nxt     = {bcd_r[BCD_W-5:0], 4'd0};
      dig_cnt_nxt = dig_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    bin_r     <= bin_nxt;
    bcd_r     <= bcd_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    dig_cnt_r <= dig_cnt_nxt;
  end

  assign top_dig      = bcd_r[BCD_W-1 -: 4];
  assign sts.bit_done = (bit_cnt_r == BIT_CNT_W'(VALUE_WIDTH - 1));
  assign sts.top_zero = (top_dig == 4'd0);
  assign sts.dig_last = (dig_cnt_r == DIG_W'(NUM_DIGITS - 1));
  assign digit_char   = ASCII_ZERO + {2'b00, top_dig};
  assign last_digit   = sts.dig_last;

endmodule
`default_nettype wire

@@ rtl/b2da_ctrl.sv @@
// controller: sequences load, conversion, zero skip and digit output
`default_nettype none
module b2da_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire b2da_pkg::sts_t sts,
  output b2da_pkg::cmd_t      cmd
);
  import b2da_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (sts.bit_done) state_nxt = ST_SKIP;
      end
      ST_SKIP: begin
        if (!sts.top_zero || sts.dig_last) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready && sts.dig_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd.load      = 1'b0;
    cmd.shift_bit = 1'b0;
    cmd.shift_dig = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CONV: begin
        cmd.shift_bit = 1'b1;
      end
      ST_SKIP: begin
        // drop leading zeros, keep at least the last digit
        cmd.shift_dig = sts.top_zero && !sts.dig_last;
      end
      ST_EMIT: begin
        out_valid     = 1'b1;
        cmd.shift_dig = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/binary_to_decimal_ascii_core.sv @@
// top level of the binary to decimal ascii converter
//
// in_if carries one unsigned 64-bit value per word (number_in); only the low
// VALUE_WIDTH bits are used. out_if returns the decimal digits of that value
// as ascii codes '0'..'9' (digit_char), most significant first, no leading
// zeros, with last_digit high on the final word. zero gives a single '0'.
// one value is converted at a time: in_if.ready is high only while idle.
// after the accept, the shift-and-add-3 loop shifts in all VALUE_WIDTH bits,
// then leading zero digits are dropped one per cycle, then one digit word
// is offered per cycle while the receiver holds out_if.ready high. the next
// value is taken only after the last digit word has been taken. when the
// receiver holds out_if.ready low the current digit stays on the port
// unchanged until taken. reset (rst_n low at a clock edge) returns the
// controller to idle and drops any conversion in flight; the datapath holds
// no state that needs clearing.
`default_nettype none
module binary_to_decimal_ascii_core (
  input  wire logic    clk,
  input  wire logic    rst_n,
  b2da_in_if.sink      in_if,
  b2da_out_if.source   out_if
);
  import b2da_pkg::*;

  cmd_t cmd;
  sts_t sts;

  b2da_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  b2da_dp u_dp (
    .clk        (clk),
    .number_in  (in_if.number_in),
    .cmd        (cmd),
    .sts        (sts),
    .digit_char (out_if.digit_char),
    .last_digit (out_if.last_digit)
  );

endmodule
`default_nettype wire

@@ rtl/b2da_checker.sv @@
// port-level assertions for the converter and their bind to the top level
`default_nettype none
module b2da_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [5:0] digit_char,
  input wire logic       last_digit
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(digit_char) && $stable(last_digit))
    else $error("output word changed while stalled");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (digit_char >= 6'd48) && (digit_char <= 6'd57))
    else $error("digit outside ascii range");

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while digits pending");

  a_conv_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid && !in_ready)
    else $error("output or new input right after accept");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && last_digit |=> in_ready && !out_valid)
    else $error("not idle after last digit");

endmodule

bind binary_to_decimal_ascii_core b2da_checker u_b2da_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .digit_char (out_if.digit_char),
  .last_digit (out_if.last_digit)
);
`default_nettype wire

@@ tb/binary_to_decimal_ascii_core_tb.sv @@
// self-checking testbench for the binary to decimal ascii converter
`timescale 1ns / 100ps
`default_nettype none
module binary_to_decimal_ascii_core_tb;
  import b2da_pkg::*;

  typedef struct {
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;
  } digit_word_t;

  class digit_scoreboard;
    digit_word_t pending_digits[$];
    int          mismatch_count = 0;

    // split the masked value into decimal digits, most significant first
    function void note_value(logic [IN_W-1:0] raw);
      logic [63:0]  width_mask;
      logic [63:0]  rest;
      logic [3:0]   rev_digits[20];
      int           n;
      digit_word_t  w;
      width_mask = (VALUE_WIDTH >= 64) ? '1 : ((64'h1 << VALUE_WIDTH) - 64'h1);
      rest = raw & width_mask;
      n = 0;
      do begin
        rev_digits[n] = 4'(rest % 64'd10);
        rest = rest / 64'd10;
        n++;
      end while (rest != 0 && n < 20);
      for (int k = n - 1; k >= 0; k--) begin
        w.digit_char = ASCII_ZERO + CHAR_W'(rev_digits[k]);
        w.last_digit = (k == 0);
        pending_digits.push_back(w);
      end
    endfunction

    function void check_digit(logic [CHAR_W-1:0] digit_char, logic last_digit);
      digit_word_t w;
      if (pending_digits.size() == 0) begin
        $error("unexpected digit word: digit_char %0d last_digit %0b", digit_char, last_digit);
        mismatch_count++;
        return;
      end
      w = pending_digits.pop_front();
      if (digit_char !== w.digit_char) begin
        $error("digit_char mismatch: expected %0d, got %0d", w.digit_char, digit_char);
        mismatch_count++;
      end
      if (last_digit !== w.last_digit) begin
        $error("last_digit mismatch: expected %0b, got %0b", w.last_digit, last_digit);
        mismatch_count++;
      end
    endfunction

    function int pending();
      return pending_digits.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   hold_req;

  b2da_in_if  in_ch ();
  b2da_out_if out_ch ();

  binary_to_decimal_ascii_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  digit_scoreboard sb = new();

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_digit(out_ch.digit_char, out_ch.last_digit);
    end
  end

  task automatic send_value(logic [63:0] v);
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.number_in <= v;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_value(v);
  endtask

  task automatic idle_gap(int n);
    @(negedge clk);
    in_ch.valid     <= 1'b0;
    in_ch.number_in <= {$urandom, $urandom};
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_drained();
    idle_gap(1);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic drive_ready(bit r, int n);
    @(negedge clk);
    out_ch.ready <= r;
    repeat (n - 1) @(negedge clk);
  endtask

  // values on a power-of-ten boundary, where the digit count changes
  function automatic logic [63:0] decade_value();
    logic [63:0] p;
    int          k;
    k = $urandom_range(0, 19);
    p = 64'd1;
    repeat (k) p = p * 64'd10;
    return $urandom_range(0, 1) ? p : p - 64'd1;
  endfunction

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    int          w;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: return decade_value();
      1, 2: return v;
      default: begin
        w = $urandom_range(1, 64);
        if (w < 64) v = v & ((64'h1 << w) - 64'h1);
        return v;
      end
    endcase
  endfunction

  // receiver: own stall pattern, plus a long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        drive_ready(1'b0, 400);
      end else begin
        case ($urandom_range(0, 3))
          0: drive_ready(1'b1, $urandom_range(20, 60));
          1: drive_ready(1'b0, $urandom_range(1, 8));
          default: begin
            drive_ready(1'b1, $urandom_range(1, 6));
            drive_ready(1'b0, $urandom_range(1, 3));
          end
        endcase
      end
    end
  end

  initial begin
    logic [63:0] directed_values[$];
    int          burst_left;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.number_in = '0;
    hold_req        = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    directed_values = '{64'd0, 64'd1, 64'd9, 64'd10, 64'd11, 64'd19, 64'd99, 64'd100,
                        64'd101, 64'd999, 64'd1000, 64'd1234567890,
                        64'd12345678901234567890, 64'd9999999999999999999,
                        64'd10000000000000000000, 64'h8000_0000_0000_0000,
                        64'h7fff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
                        64'h0000_0001_0000_0000, 64'haaaa_aaaa_aaaa_aaaa,
                        64'h5555_5555_5555_5555};
    foreach (directed_values[i]) begin
      send_value(directed_values[i]);
      if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 10));
    end
    wait_drained();

    burst_left = 0;
    for (int i = 0; i < 440; i++) begin
      if (i == 150) hold_req = 1'b1;
      if (i == 300) wait_drained();
      if (burst_left == 0) begin
        idle_gap($urandom_range(1, 20));
        burst_left = $urandom_range(1, 12);
      end
      send_value(random_value());
      burst_left--;
    end
    idle_gap(1);

    while (sb.pending() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
